// ===== src/jsu_pkg.sv =====
// Package with the request and result types, constants and decode functions of the unescaper.
package jsu_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_string;
        logic       end_of_input;
    } t_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last_of_run;
    } t_rsp;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_TEXT    = 4'd1,
        MODE_ESC     = 4'd2,
        MODE_HEX1    = 4'd3,
        MODE_HELD    = 4'd4,
        MODE_HELD_BS = 4'd5,
        MODE_HEX2    = 4'd6
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_RAW,
        KIND_UTF8
    } t_kind;

    localparam logic [1:0] ST_DATA = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam int unsigned MAX_RESULTS = 6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    localparam logic [20:0] CP_MAX1 = 21'h7F;
    localparam logic [20:0] CP_MAX2 = 21'h7FF;
    localparam logic [20:0] CP_MAX3 = 21'hFFFF;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic       ok;
        logic [7:0] val;
    } t_esc;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } t_utf8;

    function automatic t_hex f_hex(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b1;
        r.val = c[3:0];
        case (c) inside
            [8'h30:8'h39]: r.val = c[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: r.val = c[3:0] + 4'd9;
            default: begin
                r.ok  = 1'b0;
                r.val = 4'd0;
            end
        endcase
        return r;
    endfunction

    function automatic t_esc f_escape(input logic [7:0] c);
        t_esc r;
        r.ok = 1'b1;
        case (c)
            CH_QUOTE:  r.val = CH_QUOTE;
            CH_BSLASH: r.val = CH_BSLASH;
            CH_SLASH:  r.val = CH_SLASH;
            CH_B:      r.val = 8'h08;
            CH_F:      r.val = 8'h0C;
            CH_N:      r.val = 8'h0A;
            CH_R:      r.val = 8'h0D;
            CH_T:      r.val = 8'h09;
            default: begin
                r.ok  = 1'b0;
                r.val = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic t_utf8 f_utf8(input logic [20:0] cp);
        t_utf8 r;
        r.b = '0;
        if (cp <= CP_MAX1) begin
            r.b[0] = {1'b0, cp[6:0]};
            r.n    = 3'd1;
        end else if (cp <= CP_MAX2) begin
            r.b[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
            r.b[1] = UTF8_CONT | {2'd0, cp[5:0]};
            r.n    = 3'd2;
        end else if (cp <= CP_MAX3) begin
            r.b[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
            r.b[1] = UTF8_CONT | {2'd0, cp[11:6]};
            r.b[2] = UTF8_CONT | {2'd0, cp[5:0]};
            r.n    = 3'd3;
        end else begin
            r.b[0] = UTF8_LEAD4 | {5'd0, cp[20:18]};
            r.b[1] = UTF8_CONT | {2'd0, cp[17:12]};
            r.b[2] = UTF8_CONT | {2'd0, cp[11:6]};
            r.b[3] = UTF8_CONT | {2'd0, cp[5:0]};
            r.n    = 3'd4;
        end
        return r;
    endfunction

endpackage

// ===== src/json_string_unescape_utf8_top.sv =====
// Top level of the JSON string unescaper that turns escaped string bytes into UTF-8.
//
// A request carries one raw byte of a JSON string body on i_req with i_req_valid and
// o_req_ready. The first byte after the opening quote is flagged with start_of_string,
// and end_of_input marks the last byte of the stream. Results leave on o_rsp with
// o_rsp_valid and i_rsp_ready: decoded bytes, then a completion or an error result.
// A request gives zero to six results, and last_of_run marks the final one of them.
// A request passes through the input register and then the result buffer, which
// shows its first result. One request enters per cycle as long as each gives at most
// one result and the receiver does not stall; a request with several results holds
// the result buffer until all of them are taken, and the next request waits in the
// input register meanwhile. Requests that give no result leave the result buffer empty.
// When the receiver stalls, the result buffer holds its contents and one more request
// is taken into the input register before o_req_ready falls.
// Reset empties both registers and puts the decoder in its idle mode, where bytes are
// ignored until one arrives with start_of_string set.
module json_string_unescape_utf8_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  jsu_pkg::t_req     i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output jsu_pkg::t_rsp     o_rsp
);

    jsu_pkg::t_req   r_in;
    logic            r_in_valid;

    jsu_pkg::t_mode  r_mode, n_mode;
    logic [15:0]     r_hex, n_hex;
    logic [2:0]      r_cnt, n_cnt;
    logic [15:0]     r_held, n_held;

    logic [5:0][7:0] r_byte, n_byte;
    logic [5:0][1:0] r_stat, n_stat;
    logic [2:0]      r_n, n_n;
    logic [2:0]      r_idx;

    logic            w_take, w_last, w_free, w_load;

    jsu_pkg::t_mode  e_mode;
    logic [15:0]     e_hex, e_held;
    logic [2:0]      e_cnt;
    logic [7:0]      w_c;
    jsu_pkg::t_hex   w_hex;
    jsu_pkg::t_esc   w_esc;
    logic [15:0]     w_gath_hex;
    logic [2:0]      w_gath_cnt;
    logic            w_gath_full;

    logic            w_emit_held;
    jsu_pkg::t_kind  w_kind;
    logic [7:0]      w_raw;
    logic [20:0]     w_cp;
    logic            w_done, w_err, w_quiet, w_fail;

    jsu_pkg::t_utf8  w_hu, w_bu;
    logic [2:0]      w_ndata;
    logic [6:0][7:0] w_slots;

    assign o_rsp_valid = (r_n != 3'd0);
    assign w_last      = (r_idx == r_n - 3'd1);
    assign w_take      = o_rsp_valid && i_rsp_ready;
    assign w_free      = !o_rsp_valid || (w_take && w_last);
    assign w_load      = r_in_valid && w_free;
    assign o_req_ready = !r_in_valid || w_free;

    assign o_rsp.out_byte    = r_byte[r_idx];
    assign o_rsp.status      = r_stat[r_idx];
    assign o_rsp.last_of_run = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req_valid && o_req_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && o_req_ready) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jsu_pkg::MODE_IDLE;
            r_hex  <= '0;
            r_cnt  <= '0;
            r_held <= '0;
        end else if (w_load) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_cnt  <= n_cnt;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_idx <= '0;
        end else if (w_free) begin
            r_n   <= w_load ? n_n : 3'd0;
            r_idx <= '0;
        end else if (w_take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= n_byte;
            r_stat <= n_stat;
        end
    end

    // Next state and the decode decisions for the byte in the input register.
    always_comb begin
        w_c         = r_in.data_byte;
        w_hex       = jsu_pkg::f_hex(w_c);
        w_esc       = jsu_pkg::f_escape(w_c);
        e_mode      = r_in.start_of_string ? jsu_pkg::MODE_TEXT : r_mode;
        e_hex       = r_in.start_of_string ? 16'd0 : r_hex;
        e_cnt       = r_in.start_of_string ? 3'd0 : r_cnt;
        e_held      = r_in.start_of_string ? 16'd0 : r_held;
        w_gath_hex  = {e_hex[11:0], w_hex.val};
        w_gath_cnt  = e_cnt + 3'd1;
        w_gath_full = (w_gath_cnt >= 3'd4);

        n_mode      = e_mode;
        n_hex       = e_hex;
        n_cnt       = e_cnt;
        n_held      = e_held;
        w_emit_held = 1'b0;
        w_kind      = jsu_pkg::KIND_NONE;
        w_raw       = 8'd0;
        w_cp        = 21'd0;
        w_done      = 1'b0;
        w_err       = 1'b0;
        w_quiet     = 1'b0;

        case (e_mode)
            jsu_pkg::MODE_TEXT: begin
                if (w_c == jsu_pkg::CH_QUOTE) begin
                    w_done = 1'b1;
                    n_mode = jsu_pkg::MODE_IDLE;
                end else if (w_c == jsu_pkg::CH_BSLASH) begin
                    n_mode = jsu_pkg::MODE_ESC;
                end else begin
                    w_kind = jsu_pkg::KIND_RAW;
                    w_raw  = w_c;
                end
            end
            jsu_pkg::MODE_ESC, jsu_pkg::MODE_HELD_BS: begin
                if (e_mode == jsu_pkg::MODE_HELD_BS && w_c != jsu_pkg::CH_U) begin
                    w_emit_held = 1'b1;
                end
                n_mode = jsu_pkg::MODE_TEXT;
                if (w_c == jsu_pkg::CH_U) begin
                    n_hex  = 16'd0;
                    n_cnt  = 3'd0;
                    n_mode = (e_mode == jsu_pkg::MODE_ESC) ? jsu_pkg::MODE_HEX1
                                                           : jsu_pkg::MODE_HEX2;
                end else if (w_esc.ok) begin
                    w_kind = jsu_pkg::KIND_RAW;
                    w_raw  = w_esc.val;
                end else begin
                    w_err = 1'b1;
                end
            end
            jsu_pkg::MODE_HELD: begin
                if (w_c == jsu_pkg::CH_BSLASH) begin
                    n_mode = jsu_pkg::MODE_HELD_BS;
                end else begin
                    w_emit_held = 1'b1;
                    n_mode      = jsu_pkg::MODE_TEXT;
                    if (w_c == jsu_pkg::CH_QUOTE) begin
                        w_done = 1'b1;
                        n_mode = jsu_pkg::MODE_IDLE;
                    end else begin
                        w_kind = jsu_pkg::KIND_RAW;
                        w_raw  = w_c;
                    end
                end
            end
            jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
                if (!w_hex.ok) begin
                    w_err = 1'b1;
                end else begin
                    n_hex = w_gath_hex;
                    n_cnt = w_gath_cnt;
                    if (w_gath_full) begin
                        if (e_mode == jsu_pkg::MODE_HEX2 &&
                            w_gath_hex >= jsu_pkg::LOW_SURR_MIN &&
                            w_gath_hex <= jsu_pkg::LOW_SURR_MAX) begin
                            w_kind = jsu_pkg::KIND_UTF8;
                            w_cp   = jsu_pkg::SUPP_BASE
                                   + {1'b0, e_held[9:0], w_gath_hex[9:0]};
                            n_mode = jsu_pkg::MODE_TEXT;
                        end else begin
                            w_emit_held = (e_mode == jsu_pkg::MODE_HEX2);
                            if (w_gath_hex >= jsu_pkg::HIGH_SURR_MIN &&
                                w_gath_hex <= jsu_pkg::HIGH_SURR_MAX) begin
                                n_held = w_gath_hex;
                                n_mode = jsu_pkg::MODE_HELD;
                            end else begin
                                w_kind = jsu_pkg::KIND_UTF8;
                                w_cp   = {5'd0, w_gath_hex};
                                n_mode = jsu_pkg::MODE_TEXT;
                            end
                        end
                    end
                end
            end
            default: begin
                w_quiet = 1'b1;
                n_mode  = jsu_pkg::MODE_IDLE;
            end
        endcase

        w_fail = !w_quiet && !w_done && (w_err || r_in.end_of_input);
        if (w_fail) begin
            n_mode = jsu_pkg::MODE_IDLE;
        end
    end

    // Result slots for the byte in the input register.
    always_comb begin
        w_hu = jsu_pkg::f_utf8({5'd0, r_held});
        case (w_kind)
            jsu_pkg::KIND_RAW: begin
                w_bu      = '0;
                w_bu.b[0] = w_raw;
                w_bu.n    = 3'd1;
            end
            jsu_pkg::KIND_UTF8: w_bu = jsu_pkg::f_utf8(w_cp);
            default:            w_bu = '0;
        endcase

        w_ndata = (w_emit_held ? 3'd3 : 3'd0) + w_bu.n;
        w_slots = w_emit_held ? {w_bu.b, w_hu.b[2:0]} : {24'd0, w_bu.b};

        n_byte = w_slots[5:0];
        n_stat = '0;
        n_n    = w_ndata + {2'd0, w_done};
        if (w_done) begin
            n_stat[w_ndata] = jsu_pkg::ST_DONE;
        end
        if (w_fail) begin
            n_byte    = '0;
            n_stat    = '0;
            n_stat[0] = jsu_pkg::ST_ERR;
            n_n       = 3'd1;
        end
        if (w_quiet) begin
            n_n = 3'd0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != jsu_pkg::ST_DATA |-> o_rsp.last_of_run)
        else $error("Completion or error result is not the last of its run.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (r_idx < r_n) && (r_n <= 3'(jsu_pkg::MAX_RESULTS)))
        else $error("Result buffer index is out of range.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != jsu_pkg::ST_DATA |-> o_rsp.out_byte == 8'd0)
        else $error("Status result carries a nonzero byte.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && (w_fail || w_done) |=> r_mode == jsu_pkg::MODE_IDLE)
        else $error("Decoder did not return to idle after completion or error.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !w_take |=> o_rsp_valid && $stable(r_idx))
        else $error("Stalled result buffer moved.");

endmodule
